[design/warped_grid_point_map_unit_macros.svh]
// assertion macros for the top-level design file
`ifndef WARPED_GRID_POINT_MAP_UNIT_MACROS_SVH
`define WARPED_GRID_POINT_MAP_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define WGPM_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("wgpm assertion failed");
`define WGPM_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("wgpm assertion failed");
`else
`define WGPM_ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define WGPM_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

[design/wgpm_pkg.sv]
package wgpm_pkg;

    localparam int ADDR_W  = 12;
    localparam int COORD_W = 24;
    localparam int SCALE_W = 24;
    localparam int WGT_W   = 17;
    localparam int CFG_W   = 3;

    localparam logic [WGT_W-1:0] WGT_ONE = 17'h10000;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_MAP   = 1'b1;

    localparam logic [CFG_W-1:0] CFG_LEFT   = 3'd0;
    localparam logic [CFG_W-1:0] CFG_TOP    = 3'd1;
    localparam logic [CFG_W-1:0] CFG_SCALEX = 3'd2;
    localparam logic [CFG_W-1:0] CFG_SCALEY = 3'd3;
    localparam logic [CFG_W-1:0] CFG_COLS   = 3'd4;
    localparam logic [CFG_W-1:0] CFG_ROWS   = 3'd5;

    // three triangle corners and their weights
    typedef struct packed {
        logic [2:0][ADDR_W-1:0] addr;
        logic [2:0][WGT_W-1:0]  wgt;
    } tri_t;

endpackage

[design/wgpm_ram.sv]
module wgpm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

[design/wgpm_coord.sv]
// offset, scale and clamp of one axis, three stages
module wgpm_coord #(
    parameter int CNT_W = 6
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [wgpm_pkg::COORD_W-1:0] coord,
    input  logic signed [wgpm_pkg::COORD_W-1:0] origin,
    input  logic [wgpm_pkg::SCALE_W-1:0]        scale,
    input  logic [CNT_W-1:0]                    count,
    output logic [CNT_W-1:0]                    cell_reg,
    output logic [wgpm_pkg::WGT_W-1:0]          frac_reg
);

    localparam int DIFF_W = wgpm_pkg::COORD_W + 1;
    localparam int PROD_W = DIFF_W + wgpm_pkg::SCALE_W + 1;
    localparam int GF_W   = PROD_W - 8;
    localparam int G_W    = CNT_W + 16;

    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] rnd;
    logic [GF_W-1:0]          g_full;
    logic [G_W-1:0]           lim;
    logic [G_W-1:0]           g;
    logic [CNT_W-1:0]         cell_idx;
    logic [CNT_W-1:0]         last;

    always_comb
    begin
        rnd    = prod_reg + PROD_W'(128);
        g_full = rnd[PROD_W-1:8];
        lim    = {count, 16'b0};
        last   = count - CNT_W'(1);
        if (prod_reg <= 0)
        begin
            g = '0;
        end
        else if (g_full > GF_W'(lim))
        begin
            g = lim;
        end
        else
        begin
            g = g_full[G_W-1:0];
        end
        cell_idx = g[G_W-1:16];
        // the far edge lands in the last cell
        if (cell_idx > last)
        begin
            cell_idx = last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg <= DIFF_W'(coord) - DIFF_W'(origin);
            prod_reg <= PROD_W'(diff_reg) * $signed({1'b0, scale});
            cell_reg <= cell_idx;
            frac_reg <= wgpm_pkg::WGT_W'(g - {cell_idx, 16'b0});
        end
    end

endmodule

[design/wgpm_tri.sv]
// corner addresses and barycentric weights of the containing triangle
module wgpm_tri #(
    parameter int COL_W = 6,
    parameter int ROW_W = 6
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [COL_W-1:0]           col,
    input  logic [ROW_W-1:0]           row,
    input  logic [wgpm_pkg::WGT_W-1:0] fx,
    input  logic [wgpm_pkg::WGT_W-1:0] fy,
    input  logic [COL_W-1:0]           cols,
    output wgpm_pkg::tri_t             tri_reg
);

    localparam int AW = wgpm_pkg::ADDR_W;
    localparam int WW = wgpm_pkg::WGT_W;

    logic [AW-1:0]   stride;
    logic [AW-1:0]   top_base;
    logic [AW-1:0]   tl, tr, bl, br;
    logic [WW:0]     fsum;
    logic [WW-1:0]   one;
    wgpm_pkg::tri_t  tri_c;

    always_comb
    begin
        one      = wgpm_pkg::WGT_ONE;
        stride   = AW'(cols) + AW'(1);
        top_base = AW'(AW'(row) * stride);
        tl       = top_base + AW'(col);
        tr       = tl + AW'(1);
        bl       = tl + stride;
        br       = bl + AW'(1);
        fsum     = {1'b0, fx} + {1'b0, fy};
        if ((row[0] ^ col[0]) == 1'b0)
        begin
            // diagonal from top-left to bottom-right
            if (fy <= fx)
            begin
                tri_c.addr = {br, tr, tl};
                tri_c.wgt  = {fy, fx - fy, one - fx};
            end
            else
            begin
                tri_c.addr = {bl, br, tl};
                tri_c.wgt  = {fy - fx, fx, one - fy};
            end
        end
        else if (fsum <= {1'b0, one})
        begin
            tri_c.addr = {bl, tr, tl};
            tri_c.wgt  = {fy, fx, WW'({1'b0, one} - fsum)};
        end
        else
        begin
            tri_c.addr = {bl, br, tr};
            tri_c.wgt  = {one - fx, WW'(fsum - {1'b0, one}), one - fy};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tri_reg <= tri_c;
        end
    end

endmodule

[design/wgpm_blend.sv]
// weighted sum of three corners, round and saturate, two stages
module wgpm_blend (
    input  logic                                       clk,
    input  logic                                       en,
    input  logic [2:0][wgpm_pkg::COORD_W-1:0]          corner,
    input  logic [2:0][wgpm_pkg::WGT_W-1:0]            wgt,
    output logic signed [wgpm_pkg::COORD_W-1:0]        result_reg
);

    localparam int CW    = wgpm_pkg::COORD_W;
    localparam int MUL_W = CW + wgpm_pkg::WGT_W + 1;
    localparam int SUM_W = MUL_W + 2;
    localparam int R_W   = SUM_W - 16;

    logic signed [2:0][MUL_W-1:0] mul_reg;
    logic signed [SUM_W-1:0]      sum;
    logic signed [R_W-1:0]        r;
    logic signed [CW-1:0]         sat;

    always_comb
    begin
        sum = SUM_W'($signed(mul_reg[0])) + SUM_W'($signed(mul_reg[1]))
            + SUM_W'($signed(mul_reg[2])) + SUM_W'(32768);
        r   = R_W'(sum >>> 16);
        if (r > R_W'(8388607))
        begin
            sat = CW'(8388607);
        end
        else if (r < -R_W'(8388608))
        begin
            sat = CW'(-8388608);
        end
        else
        begin
            sat = r[CW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                mul_reg[k] <= MUL_W'($signed(corner[k])) * $signed({1'b0, wgt[k]});
            end
            result_reg <= sat;
        end
    end

endmodule

[design/warped_grid_point_map_unit.sv]
// pipeline: a map item's result appears on m_tdata after the coordinate, triangle, store and blend stages
// throughput: one item per cycle; a full output register with m_tready low
//   stalls every stage together
// reset: rst_n clears valid bits and sets configuration registers to their reset values; vertex
//   stores are not cleared and must be written before use
`include "warped_grid_point_map_unit_macros.svh"
module warped_grid_point_map_unit #(
    parameter int MAX_COLUMNS = 63,
    parameter int MAX_ROWS    = 63
) (
    input  logic        clk,
    input  logic        rst_n,
    // item input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // vertex_index[11:0], x_coord[35:12], y_coord[59:36]
    input  logic        s_tuser,   // opcode
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // mapped_x[23:0], mapped_y[47:24]
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int COL_W = $clog2(MAX_COLUMNS + 1);
    localparam int ROW_W = $clog2(MAX_ROWS + 1);
    localparam int AW    = wgpm_pkg::ADDR_W;
    localparam int CW    = wgpm_pkg::COORD_W;
    localparam int DEPTH = 1 << AW;

    // configuration registers
    logic signed [CW-1:0] left_reg;
    logic signed [CW-1:0] top_reg;
    logic [23:0]          scale_x_reg;
    logic [23:0]          scale_y_reg;
    logic [5:0]           cols_cfg_reg;
    logic [5:0]           rows_cfg_reg;

    logic [COL_W-1:0]     cols;
    logic [ROW_W-1:0]     rows;

    // pipeline control: valid of stages one to seven
    logic                 en;
    logic [6:0]           vld_reg;
    logic [3:0]           op_reg;
    logic [3:0][AW-1:0]   idx_reg;
    logic [3:0][CW-1:0]   x_reg;
    logic [3:0][CW-1:0]   y_reg;

    logic [COL_W-1:0]     col3;
    logic [ROW_W-1:0]     row3;
    logic [wgpm_pkg::WGT_W-1:0] fx3, fy3;
    wgpm_pkg::tri_t       tri4;
    logic [2:0][wgpm_pkg::WGT_W-1:0] wgt5_reg;
    logic [2:0][CW-1:0]   vx5, vy5;
    logic                 ram_wr;
    logic signed [CW-1:0] mx, my;

    assign cfg_ready = 1'b1;
    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign m_tvalid  = vld_reg[6];
    assign m_tdata   = {my, mx};

    // grid sizes held to the supported range
    always_comb
    begin
        if (cols_cfg_reg < 6'd2)
        begin
            cols = COL_W'(2);
        end
        else if (32'(cols_cfg_reg) > MAX_COLUMNS)
        begin
            cols = COL_W'(MAX_COLUMNS);
        end
        else
        begin
            cols = COL_W'(cols_cfg_reg);
        end
        if (rows_cfg_reg < 6'd2)
        begin
            rows = ROW_W'(2);
        end
        else if (32'(rows_cfg_reg) > MAX_ROWS)
        begin
            rows = ROW_W'(MAX_ROWS);
        end
        else
        begin
            rows = ROW_W'(rows_cfg_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg     <= '0;
            top_reg      <= '0;
            scale_x_reg  <= 24'd65536;
            scale_y_reg  <= 24'd65536;
            cols_cfg_reg <= 6'd2;
            rows_cfg_reg <= 6'd2;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                wgpm_pkg::CFG_LEFT:   left_reg     <= cfg_data;
                wgpm_pkg::CFG_TOP:    top_reg      <= cfg_data;
                wgpm_pkg::CFG_SCALEX: scale_x_reg  <= cfg_data;
                wgpm_pkg::CFG_SCALEY: scale_y_reg  <= cfg_data;
                wgpm_pkg::CFG_COLS:   cols_cfg_reg <= cfg_data[5:0];
                wgpm_pkg::CFG_ROWS:   rows_cfg_reg <= cfg_data[5:0];
                default:              ;
            endcase
        end
    end

    // valid bits; past the store stage only map items travel on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[5:4],
                        vld_reg[3] && (op_reg[3] == wgpm_pkg::OP_MAP),
                        vld_reg[2:0], s_tvalid};
        end
    end

    // item payload carried to the store stage for vertex writes, and triangle weights held for the blend
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg   <= {op_reg[2:0], s_tuser};
            idx_reg  <= {idx_reg[2:0], s_tdata[11:0]};
            x_reg    <= {x_reg[2:0], s_tdata[35:12]};
            y_reg    <= {y_reg[2:0], s_tdata[59:36]};
            wgt5_reg <= tri4.wgt;
        end
    end

    // stages one to three: grid coordinate per axis
    wgpm_coord #(.CNT_W(COL_W)) u_coord_x (
        .clk      (clk),
        .en       (en),
        .coord    (s_tdata[35:12]),
        .origin   (left_reg),
        .scale    (scale_x_reg),
        .count    (cols),
        .cell_reg (col3),
        .frac_reg (fx3)
    );

    wgpm_coord #(.CNT_W(ROW_W)) u_coord_y (
        .clk      (clk),
        .en       (en),
        .coord    (s_tdata[59:36]),
        .origin   (top_reg),
        .scale    (scale_y_reg),
        .count    (rows),
        .cell_reg (row3),
        .frac_reg (fy3)
    );

    // stage four: triangle select
    wgpm_tri #(.COL_W(COL_W), .ROW_W(ROW_W)) u_tri (
        .clk     (clk),
        .en      (en),
        .col     (col3),
        .row     (row3),
        .fx      (fx3),
        .fy      (fy3),
        .cols    (cols),
        .tri_reg (tri4)
    );

    // stage five: vertex stores, one copy per corner so that all three read
    // in the same cycle; writes and reads share this stage, which keeps their order
    assign ram_wr = en && vld_reg[3] && (op_reg[3] == wgpm_pkg::OP_WRITE);

    for (genvar k = 0; k < 3; k++)
    begin : g_store
        wgpm_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_ram_x (
            .clk     (clk),
            .wr_en   (ram_wr),
            .wr_addr (idx_reg[3]),
            .wr_data (x_reg[3]),
            .rd_en   (en),
            .rd_addr (tri4.addr[k]),
            .rd_data (vx5[k])
        );
        wgpm_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_ram_y (
            .clk     (clk),
            .wr_en   (ram_wr),
            .wr_addr (idx_reg[3]),
            .wr_data (y_reg[3]),
            .rd_en   (en),
            .rd_addr (tri4.addr[k]),
            .rd_data (vy5[k])
        );
    end

    // stages six and seven: blend, output register in the last stage
    wgpm_blend u_blend_x (
        .clk        (clk),
        .en         (en),
        .corner     (vx5),
        .wgt        (wgt5_reg),
        .result_reg (mx)
    );

    wgpm_blend u_blend_y (
        .clk        (clk),
        .en         (en),
        .corner     (vy5),
        .wgt        (wgt5_reg),
        .result_reg (my)
    );

    // input only stalls behind a held result
    `WGPM_ASSERT_IMPLIES(a_stall_cause, clk, rst_n, !s_tready, m_tvalid && !m_tready)
    // chosen cell lies inside the grid
    `WGPM_ASSERT_IMPLIES(a_cell_range, clk, rst_n, vld_reg[2], (col3 < cols) && (row3 < rows))
    // barycentric weights sum to one
    `WGPM_ASSERT_IMPLIES(a_wgt_sum, clk, rst_n, vld_reg[3] && (op_reg[3] == wgpm_pkg::OP_MAP),
        (19'(tri4.wgt[0]) + 19'(tri4.wgt[1]) + 19'(tri4.wgt[2])) == 19'(wgpm_pkg::WGT_ONE))
    // a map item in the product stage reaches the output next
    `WGPM_ASSERT_NEXT(a_out_follow, clk, rst_n, en && vld_reg[5], m_tvalid)

endmodule
